// File: sv/csc_pkg.sv
// ----------------------------------------------------------------------------
// CpG site counter package
// Shared types, widths and character codes for the CpG site counter.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Counter table geometry.
  localparam int SITE_TABLE_DEPTH = 65536;
  localparam int SITE_AW          = $clog2(SITE_TABLE_DEPTH);
  localparam int CNT_W            = 16;
  localparam int NUM_CATS         = 6;
  localparam int ROW_W            = NUM_CATS * CNT_W;
  localparam int POS_W            = 16;
  localparam int CHAR_W           = 8;

  typedef logic [SITE_AW-1:0] site_idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam cnt_t  CNT_MAX           = '1;
  localparam char_t MIN_QUALITY_RESET = 8'd33;

  // ASCII codes compared against the reference and read bases.
  localparam char_t CHAR_UC_C = 8'h43;
  localparam char_t CHAR_LC_C = 8'h63;
  localparam char_t CHAR_UC_G = 8'h47;
  localparam char_t CHAR_LC_G = 8'h67;
  localparam char_t CHAR_UC_T = 8'h54;
  localparam char_t CHAR_UC_A = 8'h41;

  // Counter categories; the code is also the lane in a table row.
  typedef enum logic [2:0] {
    CAT_WC     = 3'd0,
    CAT_WT     = 3'd1,
    CAT_WOTHER = 3'd2,
    CAT_CC     = 3'd3,
    CAT_CT     = 3'd4,
    CAT_COTHER = 3'd5
  } cat_e;

  // Decision made for one base at acceptance.
  typedef struct packed {
    logic take;
    cat_e cat;
  } sort_t;

  // Most recent row written by an item, used to bypass the memory.
  typedef struct packed {
    logic      valid;
    site_idx_t idx;
    row_t      row;
  } fwd_t;

endpackage

// File: sv/csc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module csc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/csc_classify.sv
// ----------------------------------------------------------------------------
// CpG base classifier
// Decides whether an incoming base is counted and which counter it hits.
// ----------------------------------------------------------------------------
module csc_classify (
  input  csc_pkg::char_t min_quality,
  input  csc_pkg::char_t ref_base,
  input  csc_pkg::char_t ref_next_base,
  input  csc_pkg::char_t read_base,
  input  csc_pkg::char_t read_next_base,
  input  logic           last_in_read,
  input  csc_pkg::char_t base_quality,
  input  logic           watson_strand,
  output csc_pkg::sort_t sort
);

  logic is_cpg;
  logic take;

  // A CpG site is C or c on the reference followed by G or g.
  assign is_cpg = ((ref_base == csc_pkg::CHAR_UC_C) || (ref_base == csc_pkg::CHAR_LC_C)) &&
                  ((ref_next_base == csc_pkg::CHAR_UC_G) ||
                   (ref_next_base == csc_pkg::CHAR_LC_G));

  // The last base of a crick read has no next base to judge and is skipped.
  assign take = is_cpg && (base_quality >= min_quality) && (watson_strand || !last_in_read);

  // Watson judges the read base, crick judges the next read base.
  always_comb begin
    sort.take = take;
    sort.cat  = csc_pkg::CAT_WC;
    if (take) begin
      if (watson_strand) begin
        if (read_base == csc_pkg::CHAR_UC_C) begin
          sort.cat = csc_pkg::CAT_WC;
        end else if (read_base == csc_pkg::CHAR_UC_T) begin
          sort.cat = csc_pkg::CAT_WT;
        end else begin
          sort.cat = csc_pkg::CAT_WOTHER;
        end
      end else begin
        if (read_next_base == csc_pkg::CHAR_UC_G) begin
          sort.cat = csc_pkg::CAT_CC;
        end else if (read_next_base == csc_pkg::CHAR_UC_A) begin
          sort.cat = csc_pkg::CAT_CT;
        end else begin
          sort.cat = csc_pkg::CAT_COTHER;
        end
      end
    end
  end

endmodule

// File: sv/csc_update.sv
// ----------------------------------------------------------------------------
// CpG counter row update
// Merges the memory row with the last written row, then bumps the
// selected counter lane with saturation.
// ----------------------------------------------------------------------------
module csc_update (
  input  csc_pkg::row_t      rd_row,
  input  csc_pkg::fwd_t      fwd,
  input  csc_pkg::site_idx_t idx,
  input  csc_pkg::sort_t     sort,
  output csc_pkg::row_t      new_row,
  output csc_pkg::cnt_t      count_after
);

  csc_pkg::row_t cur_row;
  csc_pkg::cnt_t lane_old;
  csc_pkg::cnt_t lane_new;

  // The memory returns stale data when the previous write hit the same row.
  assign cur_row = (fwd.valid && (fwd.idx == idx)) ? fwd.row : rd_row;

  // Pick the lane of the selected category.
  always_comb begin
    lane_old = '0;
    for (int i = 0; i < csc_pkg::NUM_CATS; i++) begin
      if (sort.cat == 3'(i)) begin
        lane_old = cur_row[i*csc_pkg::CNT_W +: csc_pkg::CNT_W];
      end
    end
  end

  // Saturating increment.
  assign lane_new = (lane_old == csc_pkg::CNT_MAX) ? lane_old : lane_old + 1'b1;

  // Write the bumped lane back into the row.
  always_comb begin
    new_row = cur_row;
    for (int i = 0; i < csc_pkg::NUM_CATS; i++) begin
      if (sort.cat == 3'(i)) begin
        new_row[i*csc_pkg::CNT_W +: csc_pkg::CNT_W] = lane_new;
      end
    end
  end

  assign count_after = sort.take ? lane_new : '0;

endmodule

// File: sv/cpg_site_counter.sv
// ----------------------------------------------------------------------------
// CpG site counter
// Counts methylation calls per genome position in six saturating counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one aligned read base per word.
//   Output channel (out_valid/out_ready) returns one result word per input
//   word, in order: counted, category and the counter value after update.
//   cfg_wr_en/cfg_wr_data write min_quality; write it only while idle.
// Pipeline and throughput:
//   Results pass the update stage and an output register. One word is
//   accepted per cycle unless out_ready stalls: the counter row is read at
//   acceptance and written back from the update stage; a back-to-back hit
//   on the same position takes the row from a bypass register, not memory.
// Reset:
//   After rst the six counter tables (one 96-bit memory row per position)
//   are cleared by a pass over all 65536 rows, one row per cycle through the
//   single write port; in_ready stays low during the pass.
//   min_quality returns to 33.
// Stall:
//   When out_ready is low the result word holds, the word in the update
//   stage waits, and in_ready drops once the update stage is occupied.
// ----------------------------------------------------------------------------
module cpg_site_counter (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] position,
  input  logic [7:0]  ref_base,
  input  logic [7:0]  ref_next_base,
  input  logic [7:0]  read_base,
  input  logic [7:0]  read_next_base,
  input  logic        last_in_read,
  input  logic [7:0]  base_quality,
  input  logic        watson_strand,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        counted,
  output logic [2:0]  category,
  output logic [15:0] count_after
);

  csc_pkg::char_t     min_quality;
  logic               clearing;
  csc_pkg::site_idx_t clr_addr;

  logic               in_accept;
  csc_pkg::sort_t     in_sort;
  csc_pkg::site_idx_t in_idx;

  logic               s1_valid;
  csc_pkg::sort_t     s1_sort;
  csc_pkg::site_idx_t s1_idx;
  logic               s1_go;
  logic               s1_open;

  csc_pkg::row_t      rd_row;
  csc_pkg::row_t      new_row;
  csc_pkg::cnt_t      new_count;
  csc_pkg::fwd_t      fwd;

  logic               ram_we;
  csc_pkg::site_idx_t ram_waddr;
  csc_pkg::row_t      ram_wdata;
  logic               item_write;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_quality <= csc_pkg::MIN_QUALITY_RESET;
    end else if (cfg_wr_en) begin
      min_quality <= cfg_wr_data;
    end
  end

  // Clearing pass over the counter memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // Handshake: the update stage moves on when the output register is free.
  assign s1_go     = !out_valid || out_ready;
  assign s1_open   = !s1_valid || s1_go;
  assign in_ready  = !clearing && s1_open;
  assign in_accept = in_valid && in_ready;
  assign in_idx    = csc_pkg::site_idx_t'(position);

  csc_classify u_classify (
    .min_quality    (min_quality),
    .ref_base       (ref_base),
    .ref_next_base  (ref_next_base),
    .read_base      (read_base),
    .read_next_base (read_next_base),
    .last_in_read   (last_in_read),
    .base_quality   (base_quality),
    .watson_strand  (watson_strand),
    .sort           (in_sort)
  );

  // Update stage registers; the memory row arrives alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sort <= in_sort;
      s1_idx  <= in_idx;
    end
  end

  csc_update u_update (
    .rd_row      (rd_row),
    .fwd         (fwd),
    .idx         (s1_idx),
    .sort        (s1_sort),
    .new_row     (new_row),
    .count_after (new_count)
  );

  // Memory write: zero rows while clearing, else the updated row.
  assign item_write = s1_valid && s1_go && s1_sort.take;
  assign ram_we     = clearing || item_write;
  assign ram_waddr  = clearing ? clr_addr : s1_idx;
  assign ram_wdata  = clearing ? '0 : new_row;

  csc_ram #(
    .WIDTH (csc_pkg::ROW_W),
    .DEPTH (csc_pkg::SITE_TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_accept),
    .rd_addr (in_idx),
    .rd_data (rd_row)
  );

  // Bypass register holding the most recent item write.
  always_ff @(posedge clk) begin
    if (item_write) begin
      fwd.idx <= s1_idx;
      fwd.row <= new_row;
    end
    if (rst) begin
      fwd.valid <= 1'b0;
    end else if (item_write) begin
      fwd.valid <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid) begin
      counted     <= s1_sort.take;
      category    <= s1_sort.cat;
      count_after <= new_count;
    end
  end

  // No input word is taken while the memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input accepted during clearing pass");

  // A counted word always reports a nonzero counter.
  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && counted) |-> (count_after != '0))
    else $error("counted word with zero count");

  // A word that is not counted reports category zero and count zero.
  a_uncounted_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !counted) |-> ((category == csc_pkg::CAT_WC) && (count_after == '0)))
    else $error("uncounted word carries a category or count");

  // An accepted word always occupies the update stage next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted word lost before update stage");

  // Bypass data, once written, matches the row that was just stored.
  a_fwd_tracks: assert property (@(posedge clk) disable iff (rst)
    item_write |=> (fwd.valid && (fwd.row == $past(new_row)) && (fwd.idx == $past(s1_idx))))
    else $error("bypass register out of step with memory write");

endmodule

// File: bench/cpg_site_counter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CpG site counter testbench
// Sends aligned read bases through the valid/ready input channel and checks
// every result word against its typed call, if any, else a model of the six
// saturating site counters. Directed words come first, then random words in
// three phases with different idling on both channels and thresholds.
// ----------------------------------------------------------------------------
module cpg_site_counter_test;
  import csc_pkg::*;

  // Cycles in which no word moves on either channel before the run is
  // declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES   = 8;

  // Read letters that the package does not name.
  localparam char_t CHAR_LC_T = 8'h74;
  localparam char_t CHAR_LC_A = 8'h61;

  // One aligned read base, as it sits on the input ports.
  typedef struct packed {
    logic [15:0] position;
    char_t       ref_base;
    char_t       ref_next_base;
    char_t       read_base;
    char_t       read_next_base;
    logic        last_in_read;
    char_t       base_quality;
    logic        watson_strand;
  } base_word_t;

  // One methylation call, as it sits on the output ports.
  typedef struct packed {
    logic counted;
    cat_e category;
    cnt_t count_after;
  } call_t;

  // Directed stimulus row: optional threshold write, the word, and the
  // expected call where it is typed in by hand.
  typedef struct packed {
    logic       cfg_write;
    char_t      cfg_value;
    base_word_t word;
    logic       typed;
    call_t      want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] position;
  logic [7:0]  ref_base;
  logic [7:0]  ref_next_base;
  logic [7:0]  read_base;
  logic [7:0]  read_next_base;
  logic        last_in_read;
  logic [7:0]  base_quality;
  logic        watson_strand;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        counted;
  logic [2:0]  category;
  logic [15:0] count_after;

  // Model state: one count per category and site, and the threshold.
  bit [CNT_W-1:0] site_counts [NUM_CATS][SITE_TABLE_DEPTH];
  char_t          min_quality_now;

  call_t       calls_due[$];
  stim_row_t   directed_rows[$];
  int unsigned error_count = 0;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles = 0;

  cpg_site_counter i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .position       (position),
    .ref_base       (ref_base),
    .ref_next_base  (ref_next_base),
    .read_base      (read_base),
    .read_next_base (read_next_base),
    .last_in_read   (last_in_read),
    .base_quality   (base_quality),
    .watson_strand  (watson_strand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .counted        (counted),
    .category       (category),
    .count_after    (count_after)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sort one base into its counter and return the call it produces.
  function automatic call_t tally_base(input base_word_t w);
    call_t     r;
    logic      is_cpg;
    cat_e      c;
    site_idx_t idx;
    r      = '0;
    idx    = site_idx_t'(w.position % SITE_TABLE_DEPTH);
    is_cpg = (w.ref_base == CHAR_UC_C || w.ref_base == CHAR_LC_C) &&
             (w.ref_next_base == CHAR_UC_G || w.ref_next_base == CHAR_LC_G);
    if (is_cpg && w.base_quality >= min_quality_now &&
        (w.watson_strand || !w.last_in_read)) begin
      // Watson judges the read base; crick judges the next read base.
      if (w.watson_strand) begin
        if (w.read_base == CHAR_UC_C) c = CAT_WC;
        else if (w.read_base == CHAR_UC_T) c = CAT_WT;
        else c = CAT_WOTHER;
      end else begin
        if (w.read_next_base == CHAR_UC_G) c = CAT_CC;
        else if (w.read_next_base == CHAR_UC_A) c = CAT_CT;
        else c = CAT_COTHER;
      end
      if (site_counts[c][idx] != CNT_MAX) begin
        site_counts[c][idx] = site_counts[c][idx] + 1'b1;
      end
      r.counted     = 1'b1;
      r.category    = c;
      r.count_after = site_counts[c][idx];
    end
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic cfg_write, input char_t cfg_value,
                                         input logic [15:0] pos, input char_t rb,
                                         input char_t rnb, input char_t sb, input char_t snb,
                                         input logic last, input char_t q, input logic watson,
                                         input logic typed, input logic hit, input cat_e c,
                                         input cnt_t after);
    stim_row_t r;
    r.cfg_write           = cfg_write;
    r.cfg_value           = cfg_value;
    r.word.position       = pos;
    r.word.ref_base       = rb;
    r.word.ref_next_base  = rnb;
    r.word.read_base      = sb;
    r.word.read_next_base = snb;
    r.word.last_in_read   = last;
    r.word.base_quality   = q;
    r.word.watson_strand  = watson;
    r.typed               = typed;
    r.want.counted        = hit;
    r.want.category       = c;
    r.want.count_after    = after;
    return r;
  endfunction

  // Offer one word, wait for its handshake and queue the expected call.
  task automatic send_word(input base_word_t w, input logic typed, input call_t want);
    call_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    position       <= w.position;
    ref_base       <= w.ref_base;
    ref_next_base  <= w.ref_next_base;
    read_base      <= w.read_base;
    read_next_base <= w.read_next_base;
    last_in_read   <= w.last_in_read;
    base_quality   <= w.base_quality;
    watson_strand  <= w.watson_strand;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = tally_base(w);
    calls_due.push_back(typed ? want : predicted);
  endtask

  // Hold the input side until every queued call has come back.
  task automatic wait_drained();
    if (calls_due.size() != 0) begin
      in_valid <= 1'b0;
      while (calls_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic set_min_quality(input char_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    min_quality_now  = value;
  endtask

  // Random words: mostly CpG sites at a few hot positions, so that the
  // same counter is hit back to back, with some noise mixed in.
  task automatic run_random(input int unsigned count);
    base_word_t w;
    call_t      none;
    none = '0;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: w.position = 16'($urandom_range(7));
        6:                w.position = 16'hFFF8 + 16'($urandom_range(7));
        default:          w.position = 16'($urandom_range(65535));
      endcase
      if ($urandom_range(9) < 8) begin
        w.ref_base      = $urandom_range(1) ? CHAR_UC_C : CHAR_LC_C;
        w.ref_next_base = $urandom_range(1) ? CHAR_UC_G : CHAR_LC_G;
      end else begin
        w.ref_base      = $urandom_range(1) ? CHAR_UC_C : char_t'($urandom_range(255));
        w.ref_next_base = char_t'($urandom_range(255));
      end
      case ($urandom_range(7))
        0:       w.read_base = CHAR_UC_C;
        1:       w.read_base = CHAR_UC_T;
        2:       w.read_base = CHAR_UC_A;
        3:       w.read_base = CHAR_UC_G;
        4:       w.read_base = CHAR_LC_C;
        5:       w.read_base = CHAR_LC_T;
        default: w.read_base = char_t'($urandom_range(255));
      endcase
      case ($urandom_range(7))
        0:       w.read_next_base = CHAR_UC_G;
        1:       w.read_next_base = CHAR_UC_A;
        2:       w.read_next_base = CHAR_UC_C;
        3:       w.read_next_base = CHAR_UC_T;
        4:       w.read_next_base = CHAR_LC_G;
        5:       w.read_next_base = CHAR_LC_A;
        default: w.read_next_base = char_t'($urandom_range(255));
      endcase
      w.last_in_read  = ($urandom_range(4) == 0);
      w.watson_strand = 1'($urandom_range(1));
      // Half the qualities sit within two of the threshold.
      if ($urandom_range(1)) begin
        w.base_quality = min_quality_now + char_t'($urandom_range(4)) - 8'd2;
      end else begin
        w.base_quality = char_t'($urandom_range(255));
      end
      if ($urandom_range(99) == 0) wait_drained();
      send_word(w, 1'b0, none);
    end
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin : result_check
    call_t want;
    if (!rst && out_valid && out_ready) begin
      if (calls_due.size() == 0) begin
        $error("result word with no call expected");
        error_count++;
      end else begin
        want = calls_due.pop_front();
        if (counted !== want.counted) begin
          $error("counted: expected %0d, got %0d", want.counted, counted);
          error_count++;
        end
        if (category !== want.category) begin
          $error("category: expected %0d, got %0d", want.category, category);
          error_count++;
        end
        if (count_after !== want.count_after) begin
          $error("count_after: expected %0d, got %0d", want.count_after, count_after);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    position        = '0;
    ref_base        = '0;
    ref_next_base   = '0;
    read_base       = '0;
    read_next_base  = '0;
    last_in_read    = 1'b0;
    base_quality    = '0;
    watson_strand   = 1'b0;
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    min_quality_now = MIN_QUALITY_RESET;

    // Threshold at its reset value: first hits, repeat hit on one site,
    // quality just below the threshold.
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'h0000, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'd33, 1'b1, 1'b1, 1'b1, CAT_WC, 16'd1));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'h0000, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'd33, 1'b1, 1'b1, 1'b1, CAT_WC, 16'd2));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'h0000, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'd32, 1'b1, 1'b1, 1'b0, CAT_WC, 16'd0));
    // Watson categories; a lower case read letter counts as other.
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'hFFFF, CHAR_LC_C, CHAR_LC_G, CHAR_UC_T,
                                     CHAR_UC_G, 1'b0, 8'd40, 1'b1, 1'b1, 1'b1, CAT_WT, 16'd1));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd100, CHAR_UC_C, CHAR_LC_G, CHAR_LC_C,
                                     CHAR_UC_G, 1'b0, 8'd40, 1'b1, 1'b1, 1'b1, CAT_WOTHER, 16'd1));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd100, CHAR_LC_C, CHAR_UC_G, CHAR_UC_A,
                                     CHAR_UC_G, 1'b0, 8'd40, 1'b1, 1'b1, 1'b1, CAT_WOTHER, 16'd2));
    // Crick categories judged on the next read base; last base skipped.
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd200, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'd40, 1'b0, 1'b1, 1'b1, CAT_CC, 16'd1));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd200, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_A, 1'b0, 8'd40, 1'b0, 1'b1, 1'b1, CAT_CT, 16'd1));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd200, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_LC_G, 1'b0, 8'd40, 1'b0, 1'b1, 1'b1, CAT_COTHER, 16'd1));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd200, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b1, 8'd40, 1'b0, 1'b1, 1'b0, CAT_WC, 16'd0));
    // The last base of a read still counts on watson.
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd300, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b1, 8'd40, 1'b1, 1'b1, 1'b1, CAT_WC, 16'd1));
    // No CpG in the reference, then all fields at their extremes.
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd300, CHAR_UC_C, CHAR_UC_A, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'd40, 1'b1, 1'b1, 1'b0, CAT_WC, 16'd0));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd300, CHAR_UC_G, CHAR_UC_C, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'd40, 1'b1, 1'b1, 1'b0, CAT_WC, 16'd0));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
                                     8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, CAT_WC, 16'd0));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'h0000, 8'h00, 8'h00, 8'h00,
                                     8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, CAT_WC, 16'd0));
    // Threshold at zero lets quality zero through.
    directed_rows.push_back(stim_row(1'b1, 8'd0, 16'd400, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1, CAT_WC, 16'd1));
    // Threshold at the top: only quality 255 counts.
    directed_rows.push_back(stim_row(1'b1, 8'hFF, 16'd400, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'hFE, 1'b1, 1'b1, 1'b0, CAT_WC, 16'd0));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'd400, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_G, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, CAT_WC, 16'd2));
    // Same site, different counters; then one more site.
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'h0000, CHAR_UC_C, CHAR_UC_G, CHAR_UC_G,
                                     CHAR_UC_A, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1, CAT_CT, 16'd1));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'h0000, CHAR_UC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_A, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0, CAT_WC, 16'd0));
    directed_rows.push_back(stim_row(1'b0, 8'd0, 16'h8000, CHAR_LC_C, CHAR_UC_G, CHAR_UC_C,
                                     CHAR_UC_T, 1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, CAT_WC, 16'd0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words, no idling on either side.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_write) begin
        wait_drained();
        set_min_quality(directed_rows[i].cfg_value);
      end
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases: sender idles lightly and receiver heavily, then the
    // other way round, then neither idles.
    wait_drained();
    set_min_quality(char_t'($urandom_range(60, 20)));
    send_gap_pct   = 8;
    recv_stall_pct = 63;
    run_random(450);

    wait_drained();
    set_min_quality(8'd0);
    send_gap_pct   = 63;
    recv_stall_pct = 8;
    run_random(450);

    wait_drained();
    set_min_quality(MIN_QUALITY_RESET);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(400);

    // Let the pipeline empty and watch for stray result words.
    in_valid <= 1'b0;
    while (calls_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/csc_pkg.sv
sv/csc_ram.sv
sv/csc_classify.sv
sv/csc_update.sv
sv/cpg_site_counter.sv
bench/cpg_site_counter_test.sv
